// File: rtl/lhs_pkg.sv
// Shared constants, payload types and control structs for the hash set
`default_nettype none
package lhs_pkg;

  localparam int SLOTS      = 1024;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int SIZE_BITS  = SLOT_BITS + 1;
  localparam int KEY_BITS   = 32;
  localparam int IDX_BITS   = $clog2(KEY_BITS);
  localparam int MIN_SIZE   = 10;
  localparam int SIZE_RESET = 1024;

  localparam logic ACT_FIND   = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  typedef struct packed {
    logic                action;
    logic [KEY_BITS-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic                 was_present;
    logic [SLOT_BITS-1:0] slot;
    logic                 table_full;
    logic [SIZE_BITS-1:0] occupied;
    logic                 load_over_half;
  } out_item_t;

  typedef struct packed {
    logic                used;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic div_step;
    logic probe_start;
    logic check;
    logic emit;
  } lhs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic probe_end;
    logic out_free;
  } lhs_status_t;

endpackage
`default_nettype wire

// File: rtl/lhs_ctrl.sv
// Sequencer for clearing, remainder, probe and result steps
`default_nettype none
module lhs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lhs_pkg::lhs_status_t status,
  output lhs_pkg::lhs_cmd_t    cmd
);
  import lhs_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DIVIDE = 7'b0000100,
    ST_SETUP  = 7'b0001000,
    ST_READ   = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.probe_start = 1'b1;
        state_next      = ST_READ;
      end
      // read data for the current slot lands at the end of this cycle
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.probe_end ? ST_RESULT : ST_READ;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/lhs_datapath.sv
// Remainder unit, slot memory, probe registers and result register
`default_nettype none
module lhs_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lhs_pkg::SIZE_BITS-1:0] cfg_wr_data,
  input  lhs_pkg::in_item_t             in_item,
  input  lhs_pkg::lhs_cmd_t             cmd,
  output lhs_pkg::lhs_status_t          status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lhs_pkg::out_item_t            out_item
);
  import lhs_pkg::*;

  logic [SIZE_BITS-1:0] table_size;
  logic [SIZE_BITS-1:0] eff_size;

  logic                 insert;
  logic [KEY_BITS-1:0]  key;
  logic [IDX_BITS-1:0]  bit_idx;
  logic [SIZE_BITS-1:0] rem;
  logic [SIZE_BITS:0]   rem_shift;

  logic [SLOT_BITS-1:0] pos;
  logic [SIZE_BITS-1:0] probes;
  logic [SLOT_BITS-1:0] clr_addr;
  logic [SIZE_BITS-1:0] used_count;

  logic res_present;
  logic res_full;

  entry_t mem [SLOTS];
  entry_t rdata;

  logic   chk_empty, chk_match, chk_last;
  logic   do_write;
  logic [SLOT_BITS-1:0] wr_addr;
  entry_t wr_data;
  logic [SIZE_BITS-1:0] pos_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_BITS'(SIZE_RESET);
    end else if (cfg_wr_en) begin
      table_size <= cfg_wr_data;
    end
  end

  always_comb begin
    if (table_size < SIZE_BITS'(MIN_SIZE)) begin
      eff_size = SIZE_BITS'(MIN_SIZE);
    end else if (table_size > SIZE_BITS'(SLOTS)) begin
      eff_size = SIZE_BITS'(SLOTS);
    end else begin
      eff_size = table_size;
    end
  end

  // restoring remainder, one key bit per cycle, MSB first
  assign rem_shift = {rem, key[bit_idx]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      insert  <= (in_item.action == ACT_INSERT);
      key     <= in_item.key;
      bit_idx <= IDX_BITS'(KEY_BITS - 1);
      rem     <= '0;
    end else if (cmd.div_step) begin
      bit_idx <= bit_idx - 1'b1;
      if (rem_shift >= {1'b0, eff_size}) begin
        rem <= SIZE_BITS'(rem_shift - {1'b0, eff_size});
      end else begin
        rem <= rem_shift[SIZE_BITS-1:0];
      end
    end
  end

  assign chk_empty = !rdata.used;
  assign chk_match = rdata.used && (rdata.key == key);
  assign chk_last  = (probes == eff_size - 1'b1);
  assign pos_inc   = {1'b0, pos} + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      pos    <= rem[SLOT_BITS-1:0];
      probes <= '0;
    end else if (cmd.check && !(chk_empty || chk_match || chk_last)) begin
      pos    <= (pos_inc >= eff_size) ? '0 : pos_inc[SLOT_BITS-1:0];
      probes <= probes + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      res_present <= chk_match;
      res_full    <= !chk_empty && !chk_match;
    end
  end

  // slot memory: one write port shared by clearing and insert, one read port
  assign do_write = cmd.clear_step || (cmd.check && chk_empty && insert);
  assign wr_addr  = cmd.clear_step ? clr_addr : pos;
  always_comb begin
    wr_data.used = !cmd.clear_step;
    wr_data.key  = key;
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      used_count <= '0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.check && chk_empty && insert) used_count <= used_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.was_present    <= res_present;
      out_item.slot           <= res_full ? rem[SLOT_BITS-1:0] : pos;
      out_item.table_full     <= res_full;
      out_item.occupied       <= used_count;
      out_item.load_over_half <= ({used_count, 1'b0} > {1'b0, eff_size});
    end
  end

  assign status.clear_last = (clr_addr == SLOT_BITS'(SLOTS - 1));
  assign status.div_last   = (bit_idx == '0);
  assign status.probe_end  = chk_empty || chk_match || chk_last;
  assign status.out_free   = !out_valid || !out_stall;

endmodule
`default_nettype wire

// File: rtl/linear_probe_hash_set.sv
// Top level of the linear-probing hash set
`default_nettype none
// Hash set of 32-bit keys in a 1024-entry open-addressed table.
// Input channel (in_valid/in_stall/in_item): one item per request, action 0 = find,
// 1 = insert. The home slot is key mod the clamped table_size (10..1024); probing
// walks forward with wraparound until it finds the key or an empty slot or has seen every slot.
// Output channel (out_valid/out_stall/out_item): exactly one result item per request.
// Steps per item: an accept step, a bit-serial remainder over the key bits (MSB first), a
// setup step, a registered memory read then a compare for each slot probed, and a result
// step; one item is worked on at a time.
// The output register lets the next item be accepted while a result waits; a
// finished item waits in its result step until the output register is free.
// Reset: after rst the block sweeps all 1024 slots of the slot memory, one slot per cycle,
// with in_stall high; table_size returns to 1024 and the count to 0.
// cfg_wr_en/cfg_wr_data write table_size; write it only while the block is idle.
module linear_probe_hash_set (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lhs_pkg::SIZE_BITS-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lhs_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lhs_pkg::out_item_t            out_item
);
  import lhs_pkg::*;

  lhs_cmd_t    cmd;
  lhs_status_t status;

  lhs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lhs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

// File: rtl/lhs_checker.sv
// Port-level checks for the hash set, bound to the top level
`default_nettype none
module lhs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input lhs_pkg::out_item_t out_item,
  input logic               out_valid,
  input logic               out_stall
);
  import lhs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.table_full |-> !out_item.was_present)
    else $error("full probe reported a present key");

  a_load_needs_keys: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.load_over_half |-> out_item.occupied != '0)
    else $error("load flag with an empty table");

endmodule

bind linear_probe_hash_set lhs_checker u_lhs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire
